>>> hdl/delta_gamma_pattern_matcher_defines.svh
// Assertion macros for the delta-gamma pattern matcher.
// Included by the RTL files that carry concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef DELTA_GAMMA_PATTERN_MATCHER_DEFINES_SVH
`define DELTA_GAMMA_PATTERN_MATCHER_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DGPM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("delta_gamma_pattern_matcher: assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define DGPM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("delta_gamma_pattern_matcher: assertion failed");

`endif

>>> hdl/dgpm_pkg.sv
// Shared types and constants of the delta-gamma pattern matcher.
// Used by dgpm_cell, dgpm_cell_row, delta_gamma_pattern_matcher and tb_top; depends on nothing.
`default_nettype none

package dgpm_pkg;

  // Default sizing, handed down from the top level.
  localparam int PATTERN_MAX_DEF = 32;
  localparam int SYMBOL_BITS_DEF = 8;

  // Fixed port widths.
  localparam int SYMBOL_PORT_W = 8;
  localparam int DELTA_W       = 8;
  localparam int GAMMA_W       = 13;
  localparam int POS_W         = 32;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 13;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DELTA = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA = 1'b1;

  // Command codes of an input beat.
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } dgpm_op_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_LAUNCH = 2'd1,
    ST_SCAN   = 2'd2,
    ST_PUSH   = 2'd3
  } dgpm_state_e;

  // Control part of the compare token that walks the cell row.
  typedef struct packed {
    logic valid;
    logic ok;
  } dgpm_tok_t;

endpackage

`default_nettype wire

>>> hdl/dgpm_cell.sv
// One compare cell: holds one pattern symbol and one text symbol and updates the passing token.
// Depends on dgpm_pkg.
`default_nettype none

module dgpm_cell import dgpm_pkg::*; #(
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
  parameter int SUM_W       = 13,
  parameter int LEN_W       = 6,
  parameter int CELL_IDX    = 0
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   pat_shift_i,
  input  wire logic                   txt_shift_i,
  input  wire logic [LEN_W-1:0]       len_i,
  input  wire logic [DELTA_W-1:0]     delta_i,
  input  wire logic [SYMBOL_BITS-1:0] pat_i,
  input  wire logic [SYMBOL_BITS-1:0] txt_i,
  input  wire dgpm_tok_t              tok_i,
  input  wire logic [SUM_W-1:0]       sum_i,
  output logic [SYMBOL_BITS-1:0]      pat_o,
  output logic [SYMBOL_BITS-1:0]      txt_o,
  output dgpm_tok_t                   tok_o,
  output logic [SUM_W-1:0]            sum_o
);

  localparam int DW = (SYMBOL_BITS > DELTA_W) ? SYMBOL_BITS : DELTA_W;

  logic [SYMBOL_BITS-1:0] pat_q;
  logic [SYMBOL_BITS-1:0] txt_q;
  logic [SYMBOL_BITS-1:0] diff;
  logic                   active;
  logic                   in_range;
  dgpm_tok_t              tok_d;
  dgpm_tok_t              tok_q;
  logic [SUM_W-1:0]       sum_d;
  logic [SUM_W-1:0]       sum_q;

  // Pattern and text symbols move one cell along on their own shift strobes.
  always_ff @(posedge clk_i) begin
    if (pat_shift_i) begin
      pat_q <= pat_i;
    end
    if (txt_shift_i) begin
      txt_q <= txt_i;
    end
  end

  // Only cells below the pattern length take part in the comparison.
  always_comb begin
    active   = (LEN_W'(CELL_IDX) < len_i);
    diff     = (pat_q >= txt_q) ? (pat_q - txt_q) : (txt_q - pat_q);
    in_range = (DW'(diff) <= DW'(delta_i));
    tok_d    = tok_i;
    sum_d    = sum_i;
    if (active) begin
      tok_d.ok = tok_i.ok && in_range;
      sum_d    = sum_i + SUM_W'(diff);
    end
  end

  // The token is registered in every cell before it moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign pat_o = pat_q;
  assign txt_o = txt_q;
  assign tok_o = tok_q;
  assign sum_o = sum_q;

endmodule

`default_nettype wire

>>> hdl/dgpm_cell_row.sv
// Row of compare cells: new pattern and text symbols enter at cell 0, the token leaves the last cell.
// Depends on dgpm_pkg and dgpm_cell.
`default_nettype none

module dgpm_cell_row import dgpm_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF,
  parameter int SUM_W       = 13,
  parameter int LEN_W       = 6
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   pat_shift_i,
  input  wire logic                   txt_shift_i,
  input  wire logic [SYMBOL_BITS-1:0] sym_i,
  input  wire logic [LEN_W-1:0]       len_i,
  input  wire logic [DELTA_W-1:0]     delta_i,
  input  wire logic                   launch_i,
  output dgpm_tok_t                   tok_o,
  output logic [SUM_W-1:0]            sum_o
);

  logic [SYMBOL_BITS-1:0] pat_link [PATTERN_MAX+1];
  logic [SYMBOL_BITS-1:0] txt_link [PATTERN_MAX+1];
  dgpm_tok_t              tok_link [PATTERN_MAX+1];
  logic [SUM_W-1:0]       sum_link [PATTERN_MAX+1];

  // A fresh token starts clean: no symbol out of range yet and an empty sum.
  assign pat_link[0]       = sym_i;
  assign txt_link[0]       = sym_i;
  assign tok_link[0].valid = launch_i;
  assign tok_link[0].ok    = 1'b1;
  assign sum_link[0]       = '0;

  // Cell j holds the text symbol j places back and the pattern symbol paired with it.
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
    dgpm_cell #(
      .SYMBOL_BITS (SYMBOL_BITS),
      .SUM_W       (SUM_W),
      .LEN_W       (LEN_W),
      .CELL_IDX    (j)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .pat_shift_i (pat_shift_i),
      .txt_shift_i (txt_shift_i),
      .len_i       (len_i),
      .delta_i     (delta_i),
      .pat_i       (pat_link[j]),
      .txt_i       (txt_link[j]),
      .tok_i       (tok_link[j]),
      .sum_i       (sum_link[j]),
      .pat_o       (pat_link[j+1]),
      .txt_o       (txt_link[j+1]),
      .tok_o       (tok_link[j+1]),
      .sum_o       (sum_link[j+1])
    );
  end

  assign tok_o = tok_link[PATTERN_MAX];
  assign sum_o = sum_link[PATTERN_MAX];

endmodule

`default_nettype wire

>>> hdl/delta_gamma_pattern_matcher.sv
// Delta-gamma pattern matcher: a row of PATTERN_MAX compare cells, a command controller and
// a result register. Text symbols and pattern symbols both shift into cell 0, so cell j
// always pairs the text symbol j places back with the pattern symbol that belongs to it.
// Clear, append and end-of-text beats are handled in ST_IDLE. A text beat that completes a
// window shifts the symbol in, launches a compare token from ST_LAUNCH, waits in ST_SCAN
// as the token walks the cell row one cell per cycle, and in ST_PUSH hands a match result to
// the output register; a text beat that cannot complete a window leaves the controller idle.
// While a result waits in the output register under a stalled result channel, the input
// stalls, and a matching window holds the controller until its result can be loaded.
// Configuration writes are always accepted and must only be issued while the block is idle.
// Depends on dgpm_pkg, dgpm_cell_row and delta_gamma_pattern_matcher_defines.svh.
`default_nettype none
`include "delta_gamma_pattern_matcher_defines.svh"

module delta_gamma_pattern_matcher import dgpm_pkg::*; #(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // Command channel.
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire logic [1:0]               opcode_i,
  input  wire logic [SYMBOL_PORT_W-1:0] symbol_value_i,
  // Result channel.
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output logic                          match_found_o,
  output logic [POS_W-1:0]              match_position_o,
  output logic                          no_match_o,
  output logic                          bad_pattern_o,
  // Configuration write channel.
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int LEN_W   = $clog2(PATTERN_MAX + 1);
  localparam int MAX_SUM = PATTERN_MAX * ((1 << SYMBOL_BITS) - 1);
  localparam int SUM_W   = (MAX_SUM > 1) ? $clog2(MAX_SUM + 1) : 1;
  localparam int CMP_W   = (SUM_W > GAMMA_W) ? SUM_W : GAMMA_W;

  dgpm_state_e            state_q, state_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic [POS_W-1:0]       count_q, count_d;
  logic                   any_q, any_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic                   hit_q, hit_d;
  logic [DELTA_W-1:0]     delta_q;
  logic [GAMMA_W-1:0]     gamma_q;

  logic                   out_valid_q;
  logic                   found_q, none_q, bad_q;
  logic [POS_W-1:0]       opos_q;

  logic                   in_acc;
  logic                   out_free;
  dgpm_op_e               op;
  logic [SYMBOL_BITS-1:0] sym;
  logic [POS_W-1:0]       count_inc;
  logic                   pat_shift, txt_shift, launch;
  logic                   load, ld_found, ld_none, ld_bad;
  logic [POS_W-1:0]       ld_pos;
  dgpm_tok_t              row_tok;
  logic [SUM_W-1:0]       row_sum;

  // Handshake: beats are taken only when idle and with room in the output register.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE) || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign op         = dgpm_op_e'(opcode_i);
  assign sym        = SYMBOL_BITS'({{SYMBOL_BITS{1'b0}}, symbol_value_i});
  assign count_inc  = count_q + POS_W'(1);
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= '0;
      gamma_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DELTA: delta_q <= cfg_data_i[DELTA_W-1:0];
        CFG_GAMMA: gamma_q <= cfg_data_i[GAMMA_W-1:0];
        default:   ;
      endcase
    end
  end

  // Compare row.
  dgpm_cell_row #(
    .PATTERN_MAX (PATTERN_MAX),
    .SYMBOL_BITS (SYMBOL_BITS),
    .SUM_W       (SUM_W),
    .LEN_W       (LEN_W)
  ) u_row (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pat_shift_i (pat_shift),
    .txt_shift_i (txt_shift),
    .sym_i       (sym),
    .len_i       (len_q),
    .delta_i     (delta_q),
    .launch_i    (launch),
    .tok_o       (row_tok),
    .sum_o       (row_sum)
  );

  // Controller state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      count_q <= '0;
      any_q   <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      count_q <= count_d;
      any_q   <= any_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
  end

  // Next state, command decode and result selection.
  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    count_d   = count_q;
    any_d     = any_q;
    pos_d     = pos_q;
    hit_d     = hit_q;
    pat_shift = 1'b0;
    txt_shift = 1'b0;
    launch    = 1'b0;
    load      = 1'b0;
    ld_found  = 1'b0;
    ld_pos    = '0;
    ld_none   = 1'b0;
    ld_bad    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (op)
            OP_CLEAR: begin
              len_d   = '0;
              count_d = '0;
              any_d   = 1'b0;
            end
            OP_APPEND: begin
              // A full pattern ignores further symbols.
              if (len_q < LEN_W'(PATTERN_MAX)) begin
                pat_shift = 1'b1;
                len_d     = len_q + LEN_W'(1);
              end
            end
            OP_TEXT: begin
              txt_shift = 1'b1;
              count_d   = count_inc;
              if ((len_q != '0) && (count_inc >= POS_W'(len_q))) begin
                pos_d   = count_inc - POS_W'(len_q);
                state_d = ST_LAUNCH;
              end
            end
            OP_END: begin
              load    = 1'b1;
              ld_none = !any_q;
              ld_bad  = (len_q == '0);
              count_d = '0;
              any_d   = 1'b0;
            end
          endcase
        end
      end
      ST_LAUNCH: begin
        // The new text symbol sits in cell 0 now; start the token.
        launch  = 1'b1;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (row_tok.valid) begin
          hit_d   = row_tok.ok && (CMP_W'(row_sum) <= CMP_W'(gamma_q));
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!hit_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          load     = 1'b1;
          ld_found = 1'b1;
          ld_pos   = pos_q;
          any_d    = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      found_q <= ld_found;
      opos_q  <= ld_pos;
      none_q  <= ld_none;
      bad_q   <= ld_bad;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign match_found_o    = found_q;
  assign match_position_o = opos_q;
  assign no_match_o       = none_q;
  assign bad_pattern_o    = bad_q;

  // The token only comes out of the row while the controller waits for it.
  `DGPM_ASSERT_IMP(a_tok_in_scan, row_tok.valid, state_q == ST_SCAN)
  // The pattern length never passes the row length.
  `DGPM_ASSERT_IMP(a_len_bound, 1'b1, len_q <= LEN_W'(PATTERN_MAX))
  // A match result carries no end-of-text flags.
  `DGPM_ASSERT_IMP(a_match_clean, out_valid_o && match_found_o, !no_match_o && !bad_pattern_o)
  // An empty pattern can never have produced a match.
  `DGPM_ASSERT_IMP(a_bad_none, out_valid_o && bad_pattern_o, no_match_o)
  // A confirmed hit with room in the output register shows up as a match next cycle.
  `DGPM_ASSERT_NXT(a_hit_push, (state_q == ST_PUSH) && hit_q && out_free,
                   out_valid_o && match_found_o)

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for delta_gamma_pattern_matcher: directed and random command beats,
// with random idle and stall on both channels, checked against a built-in predictor.
// Depends on dgpm_pkg and the RTL of delta_gamma_pattern_matcher.
`default_nettype none

module tb_top import dgpm_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PATTERN_MAX   = PATTERN_MAX_DEF;
  localparam int SYMBOL_BITS   = SYMBOL_BITS_DEF;
  localparam int SETTLE_CYCLES = 2 * (PATTERN_MAX + 3);
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_BEATS  = 850;
  localparam int PHASES        = 8;

  // One result beat of the block.
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             none;
    logic             bad;
  } match_report_t;

  // Predicts the match reports of the block and checks the ones it delivers.
  class match_scoreboard;
    bit [7:0]         pattern [PATTERN_MAX];
    int unsigned      pattern_len;
    bit [7:0]         window [PATTERN_MAX];
    bit [POS_W-1:0]   text_seen;
    bit               hit_seen;
    bit [DELTA_W-1:0] delta;
    bit [GAMMA_W-1:0] gamma;
    match_report_t    expected_reports [$];
    int unsigned      errors;
    int unsigned      text_beats;
    int unsigned      matches_checked;
    int unsigned      summaries_checked;

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_DELTA) begin
        delta = data[DELTA_W-1:0];
      end else begin
        gamma = data[GAMMA_W-1:0];
      end
    endfunction

    function void clear_text();
      foreach (window[i]) window[i] = '0;
      text_seen = '0;
      hit_seen  = 1'b0;
    endfunction

    // The newest pattern_len text symbols are compared in order with the pattern.
    function bit window_fits();
      int unsigned total;
      int          d;
      total = 0;
      for (int i = 0; i < pattern_len; i++) begin
        d = int'(pattern[i]) - int'(window[pattern_len - 1 - i]);
        if (d < 0) d = -d;
        if (d > int'(delta)) return 1'b0;
        total += d;
      end
      return total <= gamma;
    endfunction

    // Notes an accepted command beat and queues the report it causes, if any.
    function void note_beat(dgpm_op_e op, logic [7:0] sym_in);
      bit [7:0]      sym;
      match_report_t rep;
      sym = sym_in & 8'((1 << SYMBOL_BITS) - 1);
      case (op)
        OP_CLEAR: begin
          pattern_len = 0;
          clear_text();
        end
        OP_APPEND: begin
          if (pattern_len < PATTERN_MAX) begin
            pattern[pattern_len] = sym;
            pattern_len++;
          end
        end
        OP_TEXT: begin
          text_beats++;
          for (int i = PATTERN_MAX - 1; i > 0; i--) window[i] = window[i - 1];
          window[0] = sym;
          text_seen++;
          if (pattern_len != 0 && text_seen >= pattern_len && window_fits()) begin
            hit_seen     = 1'b1;
            rep.found    = 1'b1;
            rep.position = text_seen - POS_W'(pattern_len);
            rep.none     = 1'b0;
            rep.bad      = 1'b0;
            expected_reports = {expected_reports, rep};
          end
        end
        default: begin
          rep.found    = 1'b0;
          rep.position = '0;
          rep.none     = !hit_seen;
          rep.bad      = (pattern_len == 0);
          expected_reports = {expected_reports, rep};
          clear_text();
        end
      endcase
    endfunction

    function void compare_field(string name, logic [POS_W-1:0] want, logic [POS_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    // Compares a delivered report with the oldest one expected.
    function void check_report(match_report_t got);
      match_report_t want;
      if (expected_reports.size() == 0) begin
        $error("report beat arrived with nothing expected");
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      if (want.found) matches_checked++;
      else summaries_checked++;
      compare_field("match_found", POS_W'(want.found), POS_W'(got.found));
      compare_field("match_position", want.position, got.position);
      compare_field("no_match", POS_W'(want.none), POS_W'(got.none));
      compare_field("bad_pattern", POS_W'(want.bad), POS_W'(got.bad));
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [1:0]               opcode_i;
  logic [SYMBOL_PORT_W-1:0] symbol_value_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic                     match_found_o;
  logic [POS_W-1:0]         match_position_o;
  logic                     no_match_o;
  logic                     bad_pattern_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [CFG_DATA_W-1:0]    cfg_data_i;

  match_scoreboard sb;
  bit              in_burst;
  bit              out_burst;
  int unsigned     beats_sent;
  int unsigned     cycle_count;
  logic [7:0]      pattern_copy [$];

  delta_gamma_pattern_matcher dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .opcode_i         (opcode_i),
    .symbol_value_i   (symbol_value_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .match_found_o    (match_found_o),
    .match_position_o (match_position_o),
    .no_match_o       (no_match_o),
    .bad_pattern_o    (bad_pattern_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Clock with a 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // A stuck handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int unsigned draw_wait(bit burst);
    return burst ? 0 : $urandom_range(0, 17);
  endfunction

  // Result side: check each accepted beat, then stall for a freshly drawn number of cycles.
  initial begin
    int unsigned   stall_left;
    match_report_t got;
    stall_left  = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.found    = match_found_o;
        got.position = match_position_o;
        got.none     = no_match_o;
        got.bad      = bad_pattern_o;
        sb.check_report(got);
        if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
        stall_left = draw_wait(out_burst);
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // Sends one command beat after a random gap and waits until it is taken.
  task automatic send(input dgpm_op_e op, input logic [7:0] sym);
    int unsigned gap;
    gap = draw_wait(in_burst);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    symbol_value_i <= sym;
    do @(posedge clk_i); while (in_stall_o);
    case (op)
      OP_CLEAR: begin
        pattern_copy.delete();
      end
      OP_APPEND: begin
        if (pattern_copy.size() < PATTERN_MAX) begin
          pattern_copy = {pattern_copy, sym};
        end
      end
      default: ;
    endcase
    beats_sent++;
    sb.note_beat(op, sym);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_register(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits for every expected report, then for the longest compare walk to drain.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Picks the delta and gamma of a phase; the extremes come first.
  task automatic apply_setting(input int phase);
    int unsigned d, g;
    case (phase)
      0:       begin d = 0;   g = 0;    end
      1:       begin d = 255; g = 8191; end
      2:       begin d = 1;   g = 2;    end
      3:       begin d = 255; g = 0;    end
      4:       begin d = 0;   g = 8191; end
      5:       begin d = 4;   g = 20;   end
      default: begin d = $urandom_range(0, 255); g = $urandom_range(0, 8191); end
    endcase
    // Upper data bits ride along on delta writes; only the low byte is kept.
    write_register(CFG_GAMMA, CFG_DATA_W'(g));
    write_register(CFG_DELTA, (CFG_DATA_W'($urandom) & 13'h1F00) | CFG_DATA_W'(d));
  endtask

  // Directed beats: empty pattern, extremes, append during a text and end-of-text reports.
  task automatic run_directed();
    send(OP_END, 8'h00);
    send(OP_TEXT, 8'h00);
    send(OP_TEXT, 8'hFF);
    send(OP_END, 8'hFF);
    send(OP_APPEND, 8'h00);
    send(OP_APPEND, 8'hFF);
    send(OP_TEXT, 8'h00);
    send(OP_TEXT, 8'hFF);
    send(OP_TEXT, 8'h00);
    send(OP_TEXT, 8'hFF);
    send(OP_APPEND, 8'h07);
    send(OP_TEXT, 8'h07);
    send(OP_END, 8'h55);
    send(OP_TEXT, 8'h01);
    send(OP_TEXT, 8'hAA);
    send(OP_END, 8'h00);
    send(OP_CLEAR, 8'hFF);
    send(OP_END, 8'h00);
  endtask

  // One random round: mostly a pattern and a text close to repeats of it, sometimes noise.
  task automatic play_round();
    int unsigned r, plen, tlen, lead, spread, idx;
    int          val;
    in_burst = ($urandom_range(0, 3) == 0);
    r = $urandom_range(0, 9);
    if (r >= 8) begin
      repeat ($urandom_range(3, 10)) send(dgpm_op_e'($urandom_range(0, 3)), 8'($urandom));
      return;
    end
    if ($urandom_range(0, 3) != 0) send(OP_CLEAR, 8'($urandom));
    r    = $urandom_range(0, 19);
    plen = (r < 14) ? $urandom_range(1, 5) :
           (r < 19) ? $urandom_range(6, 31) : PATTERN_MAX + $urandom_range(0, 3);
    repeat (plen) begin
      if ($urandom_range(0, 3) == 0) send(OP_APPEND, $urandom_range(0, 1) ? 8'hFF : 8'h00);
      else send(OP_APPEND, 8'($urandom));
    end
    case ($urandom_range(0, 3))
      0:       spread = 0;
      1:       spread = 1;
      2:       spread = $urandom_range(0, 6);
      default: spread = $urandom_range(0, 64);
    endcase
    lead = $urandom_range(0, 2);
    tlen = pattern_copy.size() + $urandom_range(0, 12);
    for (int k = 0; k < lead + tlen; k++) begin
      if (k == lead + 2 && $urandom_range(0, 9) == 0) send(OP_APPEND, 8'($urandom));
      if (k < lead || pattern_copy.size() == 0) begin
        val = $urandom_range(0, 255);
      end else begin
        idx = (k - lead) % pattern_copy.size();
        val = int'(pattern_copy[idx]) + int'($urandom_range(0, 2 * spread)) - int'(spread);
        if (val < 0) val = 0;
        if (val > 255) val = 255;
      end
      send(OP_TEXT, 8'(val));
    end
    if ($urandom_range(0, 9) != 0) send(OP_END, 8'($urandom));
  endtask

  // Main sequence: reset, directed part, then random phases under different settings.
  initial begin
    int unsigned goal;
    sb             = new();
    cycle_count    = 0;
    beats_sent     = 0;
    in_burst       = 1'b0;
    out_burst      = 1'b0;
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    opcode_i       <= OP_CLEAR;
    symbol_value_i <= '0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= CFG_DELTA;
    cfg_data_i     <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_register(CFG_DELTA, '0);
    write_register(CFG_GAMMA, '0);
    run_directed();
    settle();
    goal = beats_sent;
    for (int phase = 0; phase < PHASES; phase++) begin
      apply_setting(phase);
      goal += RANDOM_BEATS / PHASES;
      while (beats_sent < goal) play_round();
      settle();
    end
    $display("Drove %0d command beats (%0d text symbols); checked %0d matches and %0d summaries,",
             beats_sent, sb.text_beats, sb.matches_checked, sb.summaries_checked);
    $display("over %0d delta/gamma settings with random gaps and stalls on both channels.",
             PHASES + 1);
    if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire
